// ----- rtl/gss_pkg.sv -----
// Package for the Gauss-Seidel solver: matrix size, command codes, register indexes
// and field widths. No dependencies; imported by gauss_seidel_solver_top.
`default_nettype none

package gss_pkg;

   localparam int MAX_SIZE = 8;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = $clog2(MAX_SIZE);
   localparam int VAL_W   = 32;
   localparam int SIZE_W  = 4;
   localparam int ITER_W  = 16;
   localparam int TOL_W   = 17;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 17;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_COEFF = 2'd0,
      CMD_LOAD_RHS   = 2'd1,
      CMD_SOLVE      = 2'd2,
      CMD_NOP        = 2'd3
   } cmd_type;

   localparam logic [CSR_A_W-1:0] CSR_SIZE      = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_ITER  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_TOLERANCE = 2'd2;

   localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ----- rtl/gss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/gauss_seidel_solver_top.sv -----
// Gauss-Seidel linear solver, signed fixed point, iterative shared datapath.
// Depends on gss_pkg and gss_ram.
// Usage:
//  - Input channel (req_*): each transfer carries a command. Load commands write one
//    matrix coefficient (row, col) or one right-hand value (row), and loads can
//    stream back to back. Out-of-range rows or columns are dropped.
//  - A solve transfer sets x to one and runs sweeps until every element meets
//    |x - old| <= tol * |x| / 2^FRAC_BITS or max_iterations sweeps are done.
//    req_stall stays high for the whole run, including delivery of the results.
//  - Result channel (rsp_*): one transfer per solution element, index 0 to n-1,
//    rsp_last on the final one. Each result sits in an output register and holds
//    while rsp_stall is high; after a transfer the next element is read from RAM.
//  - Row update: each column goes through RAM read, multiply, round and
//    accumulate; then come the right-hand read, the one-bit-per-cycle
//    restoring divider (62 steps) and the tolerance check; a zero pivot or a
//    saturating quotient skips the divider. Each sweep ends in a sweep-end
//    step; start-up first initializes every x element to one.
//  - Configuration (csr_*): plain write port, to be written only while idle; the block itself does not enforce this.
//  - Reset: synchronous, returns to idle with default configuration; RAM
//    contents are not cleared and need no clearing pass.
`default_nettype none

module gauss_seidel_solver_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gss_pkg::CMD_W-1:0]     req_command,
   input  wire logic [gss_pkg::IDX_W-1:0]     req_row,
   input  wire logic [gss_pkg::IDX_W-1:0]     req_col,
   input  wire logic signed [gss_pkg::VAL_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gss_pkg::IDX_W-1:0]          rsp_index,
   output logic signed [gss_pkg::VAL_W-1:0]   rsp_solution,
   output logic                               rsp_converged,
   output logic [gss_pkg::ITER_W-1:0]         rsp_sweeps_done,
   output logic                               rsp_zero_pivot,
   output logic                               rsp_last,
   input  wire logic                          csr_write,
   input  wire logic [gss_pkg::CSR_A_W-1:0]   csr_index,
   input  wire logic [gss_pkg::CSR_D_W-1:0]   csr_data
);

   import gss_pkg::*;

   localparam int IW     = $clog2(MAX_SIZE);
   localparam int CDEPTH = MAX_SIZE * MAX_SIZE + MAX_SIZE;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int DW     = 62;
   localparam int CW     = $clog2(DW);
   localparam int NW     = (IW + 1 > SIZE_W) ? IW + 1 : SIZE_W;
   localparam logic [63:0] HALF   = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] DIVLIM = 64'd1 << (62 - FRAC_BITS);
   localparam logic [VAL_W-1:0] ONE = VAL_W'(64'd1 << FRAC_BITS);

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_ROW_RD, ST_ROW_MUL, ST_ROW_RND, ST_ROW_ACC,
      ST_RHS_RD, ST_RHS_WT, ST_DIV_SETUP, ST_DIV_RUN, ST_DIV_DONE,
      ST_CHK_MUL, ST_CHK_CMP, ST_SWEEP_END, ST_OUT_RD, ST_OUT_WT, ST_OUT_HOLD
   } state_type;

   state_type state_ff;

   // configuration
   logic [SIZE_W-1:0] size_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [TOL_W-1:0]  tol_ff;

   // sequencer counters and run flags
   logic [IW-1:0]     i_ff, j_ff, n_m1_ff, n_m1_in;
   logic [ITER_W-1:0] sweeps_ff;
   logic              all_ff, conv_ff, zp_ff;

   // shared datapath
   logic signed [63:0]      prod_ff, sum_ff, num_ff;
   logic [63:0]             rmag_ff;
   logic                    rneg_ff;
   logic signed [VAL_W-1:0] diag_ff, old_ff, xnew_ff;
   logic [DW-1:0]           dvd_ff, quo_ff;
   logic [31:0]             rem_ff, dm_ff;
   logic                    qneg_ff;
   logic [CW-1:0]           cnt_ff;
   logic [32:0]             diff_ff;
   logic [48:0]             tolx_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_index_ff;
   logic signed [VAL_W-1:0] rsp_solution_ff;
   logic                    rsp_last_ff;

   // RAM ports
   logic                 c_wr_en;
   logic [CAW-1:0]       c_wr_addr, c_rd_addr;
   logic [VAL_W-1:0]     c_rd_data;
   logic                 x_wr_en;
   logic [IW-1:0]        x_wr_addr, x_rd_addr;
   logic [VAL_W-1:0]     x_wr_data, x_rd_data;

   // combinational helpers
   logic          req_xfer, rsp_xfer;
   logic [63:0]   pmag, nmag;
   logic [32:0]   div_trial, dm_ext;
   logic          div_ge;
   logic [31:0]   xabs;
   logic signed [32:0] xdelta;
   logic [63:0]   chk_lhs;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // clamp size to 1..MAX_SIZE
   always_comb begin
      if (size_ff == '0) begin
         n_m1_in = '0;
      end else if (NW'(size_ff) > NW'(MAX_SIZE)) begin
         n_m1_in = IW'(MAX_SIZE - 1);
      end else begin
         n_m1_in = IW'(NW'(size_ff) - NW'(1));
      end
   end

   // coefficient store: matrix rows followed by the right-hand side
   assign c_wr_en = req_xfer &&
                    (((req_command == CMD_LOAD_COEFF) && (req_row < MAX_SIZE) &&
                      (req_col < MAX_SIZE)) ||
                     ((req_command == CMD_LOAD_RHS) && (req_row < MAX_SIZE)));

   always_comb begin
      if (req_command == CMD_LOAD_RHS) begin
         c_wr_addr = CAW'(MAX_SIZE * MAX_SIZE) + CAW'(req_row);
      end else begin
         c_wr_addr = CAW'(req_row) * CAW'(MAX_SIZE) + CAW'(req_col);
      end
      if (state_ff == ST_RHS_RD) begin
         c_rd_addr = CAW'(MAX_SIZE * MAX_SIZE) + CAW'(i_ff);
      end else begin
         c_rd_addr = CAW'(i_ff) * CAW'(MAX_SIZE) + CAW'(j_ff);
      end
   end

   // solution store: one read and one write port, written at init and each update
   assign x_wr_en   = (state_ff == ST_INIT) || (state_ff == ST_CHK_CMP);
   assign x_wr_addr = i_ff;
   assign x_wr_data = (state_ff == ST_INIT) ? ONE : xnew_ff;
   assign x_rd_addr = (state_ff == ST_ROW_RD) ? j_ff : i_ff;

   gss_ram #(.WIDTH(VAL_W), .DEPTH(CDEPTH)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (req_value),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   gss_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_sol_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (x_wr_addr),
      .wr_data (x_wr_data),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd_data)
   );

   always_comb begin
      pmag      = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      nmag      = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      dm_ext    = {1'b0, dm_ff};
      div_trial = {rem_ff, dvd_ff[DW-1]};
      div_ge    = (div_trial >= dm_ext);
      xabs      = 32'(32'd0 - 32'(xnew_ff));
      if (!xnew_ff[31]) begin
         xabs = 32'(xnew_ff);
      end
      xdelta    = 33'(xnew_ff) - 33'(old_ff);
      chk_lhs   = 64'(diff_ff) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_W'(8);
         max_iter_ff  <= ITER_W'(100);
         tol_ff       <= TOL_W'(7);
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SIZE:      size_ff     <= csr_data[SIZE_W-1:0];
               CSR_MAX_ITER:  max_iter_ff <= csr_data[ITER_W-1:0];
               CSR_TOLERANCE: tol_ff      <= csr_data[TOL_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_command == CMD_SOLVE)) begin
                  n_m1_ff   <= n_m1_in;
                  sweeps_ff <= '0;
                  conv_ff   <= 1'b0;
                  zp_ff     <= 1'b0;
                  i_ff      <= '0;
                  state_ff  <= ST_INIT;
               end
            end
            ST_INIT: begin
               if (i_ff == n_m1_ff) begin
                  i_ff   <= '0;
                  j_ff   <= '0;
                  all_ff <= 1'b1;
                  state_ff <= (max_iter_ff == '0) ? ST_OUT_RD : ST_ROW_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_ROW_RD: begin
               if (j_ff == '0) begin
                  sum_ff <= '0;
               end
               state_ff <= ST_ROW_MUL;
            end
            ST_ROW_MUL: begin
               prod_ff <= 64'(signed'(c_rd_data)) * 64'(signed'(x_rd_data));
               if (j_ff == i_ff) begin
                  diag_ff <= signed'(c_rd_data);
               end
               state_ff <= ST_ROW_RND;
            end
            ST_ROW_RND: begin
               // round magnitude to nearest, ties away from zero
               rmag_ff  <= (pmag + HALF) >> FRAC_BITS;
               rneg_ff  <= prod_ff[63];
               state_ff <= ST_ROW_ACC;
            end
            ST_ROW_ACC: begin
               if (j_ff != i_ff) begin
                  sum_ff <= rneg_ff ? sum_ff - signed'(rmag_ff) : sum_ff + signed'(rmag_ff);
               end
               if (j_ff == n_m1_ff) begin
                  state_ff <= ST_RHS_RD;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_RHS_RD: begin
               state_ff <= ST_RHS_WT;
            end
            ST_RHS_WT: begin
               num_ff   <= 64'(signed'(c_rd_data)) - sum_ff;
               old_ff   <= signed'(x_rd_data);
               state_ff <= ST_DIV_SETUP;
            end
            ST_DIV_SETUP: begin
               qneg_ff <= num_ff[63] != diag_ff[31];
               if (diag_ff == '0) begin
                  // zero pivot: saturate toward the numerator's sign, or zero for a zero numerator
                  zp_ff <= 1'b1;
                  if (num_ff == '0) begin
                     xnew_ff <= '0;
                  end else begin
                     xnew_ff <= num_ff[63] ? SAT_MIN : SAT_MAX;
                  end
                  state_ff <= ST_CHK_MUL;
               end else if (nmag >= DIVLIM) begin
                  xnew_ff  <= (num_ff[63] != diag_ff[31]) ? SAT_MIN : SAT_MAX;
                  state_ff <= ST_CHK_MUL;
               end else begin
                  dvd_ff   <= DW'(nmag << FRAC_BITS);
                  dm_ff    <= diag_ff[31] ? 32'(32'd0 - 32'(diag_ff)) : 32'(diag_ff);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV_RUN;
               end
            end
            ST_DIV_RUN: begin
               // restoring division, one quotient bit per cycle
               rem_ff <= div_ge ? 32'(div_trial - dm_ext) : div_trial[31:0];
               quo_ff <= {quo_ff[DW-2:0], div_ge};
               dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(DW - 1)) begin
                  state_ff <= ST_DIV_DONE;
               end
            end
            ST_DIV_DONE: begin
               if (qneg_ff) begin
                  xnew_ff <= (quo_ff > DW'(64'h8000_0000)) ? SAT_MIN
                                                           : signed'(32'(DW'(0) - quo_ff));
               end else begin
                  xnew_ff <= (quo_ff > DW'(64'h7FFF_FFFF)) ? SAT_MAX : signed'(quo_ff[31:0]);
               end
               state_ff <= ST_CHK_MUL;
            end
            ST_CHK_MUL: begin
               tolx_ff  <= 49'(tol_ff) * 49'(xabs);
               diff_ff  <= xdelta[32] ? 33'(33'd0 - xdelta) : 33'(xdelta);
               state_ff <= ST_CHK_CMP;
            end
            ST_CHK_CMP: begin
               // a zero element never counts as converged
               if ((xnew_ff == '0) || (chk_lhs > 64'(tolx_ff))) begin
                  all_ff <= 1'b0;
               end
               j_ff <= '0;
               if (i_ff == n_m1_ff) begin
                  state_ff <= ST_SWEEP_END;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_SWEEP_END: begin
               sweeps_ff <= sweeps_ff + 1'b1;
               i_ff      <= '0;
               if (all_ff) begin
                  conv_ff  <= 1'b1;
                  state_ff <= ST_OUT_RD;
               end else if ((sweeps_ff + 1'b1) == max_iter_ff) begin
                  state_ff <= ST_OUT_RD;
               end else begin
                  all_ff   <= 1'b1;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_WT;
            end
            ST_OUT_WT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_index_ff    <= IDX_W'(i_ff);
               rsp_solution_ff <= signed'(x_rd_data);
               rsp_last_ff     <= (i_ff == n_m1_ff);
               state_ff        <= ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
               // hold the result until the receiver takes it
               if (rsp_xfer) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_solution    = rsp_solution_ff;
   assign rsp_converged   = conv_ff;
   assign rsp_sweeps_done = sweeps_ff;
   assign rsp_zero_pivot  = zp_ff;
   assign rsp_last        = rsp_last_ff;

   // no new command is taken while a result is pending
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("input accepted while a result is pending");

   // the divider never runs past its last quotient bit
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (cnt_ff <= CW'(DW - 1)))
      else $error("divider step count out of range");

   // the last flag appears only on the final element
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == IDX_W'(n_m1_ff)))
      else $error("last flag on wrong element");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire
